### design/rdrt_pkg.sv
// Package for the relay de-duplication and retransmit table.
// Holds shared entry type, operation codes and the seed scrambler.
`timescale 1ns / 1ps
`default_nettype none
package rdrt_pkg;
  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;
  localparam logic [1:0] RETRY_COUNT = 2'd3;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] logger;
    logic [47:0] etime;
    logic [7:0]  kind;
    logic [1:0]  retries;
  } entry_t;

  function automatic logic [31:0] lcg_step(input logic [31:0] s);
    lcg_step = s * LCG_MUL + LCG_ADD;
  endfunction
endpackage
`default_nettype wire

### design/rdrt_cell.sv
// One table cell of the rotating ring: holds an entry and passes it on.
// Depends on rdrt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rdrt_cell import rdrt_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   shift,
  input  wire entry_t din,
  output entry_t      dout
);
  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else if (shift) begin
      dout <= din;
    end
  end
endmodule
`default_nettype wire

### design/relay_dedup_retransmit_table_core.sv
// Top level of the relay de-duplication and retransmit table.
// Uses rdrt_pkg and a ring of rdrt_cell entries that rotate past one head.
//
// channel | dir | fields (low bit up)
// s_axis  | in  | tuser: operation
//         |     | tdata: tag_id, logger_id, event_time, kind_code, retransmit,
//         |     |        time_valid
// m_axis  | out | tuser: is_transmission; tlast: last
//         |     | tdata: found, out_time, out_tag, out_kind, out_logger, out_group
// cfg     | in  | wr_en, wr_index, wr_data
//
// A record is accepted, then stored into the head cell; a request record first
// scrambles its tag with four LCG steps.
// Lookup and tick rotate the ring until slot 0 is at the head, walk all
// TABLE_DEPTH entries in slot order, then rotate on until the next write slot is
// back at the head. The steps are the accept, these rotations, an end-of-walk
// state and an answer state.
// A tick walk halts while a result waits in the stalled output register.
// Reset is synchronous and clears every cell; no item is taken while busy.
`timescale 1ns / 1ps
`default_nettype none
module relay_dedup_retransmit_table_core import rdrt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // tag,logger,time,kind,retx,tvalid
  input  wire logic [1:0]   s_axis_tuser,  // op
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [143:0]      m_axis_tdata,  // found,time,tag,kind,logger,group
  output logic              m_axis_tuser,  // tx
  output logic              m_axis_tlast,  // last
  input  wire logic         wr_en,
  input  wire logic [2:0]   wr_index,
  input  wire logic [31:0]  wr_data
);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = $clog2(TABLE_DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001, ST_SCR = 5'b00010, ST_REC = 5'b00100,
    ST_WALK = 5'b01000, ST_OUT = 5'b10000
  } state_t;

  logic [31:0] own_logger_id;
  logic [15:0] group_id;
  logic [7:0]  code_bc, code_req, code_rsp;

  state_t state;
  logic [1:0]  op;
  logic [31:0] tag, logger;
  logic [47:0] etime;
  logic [7:0]  kind;
  logic        retx, tvld, found;
  logic [CW-1:0] cnt;
  logic [4:0]  nres;
  logic [1:0]  scnt;
  logic [SW-1:0] hslot, home;
  logic [143:0] hold_data;

  // Ring: cell 0 is the head; a rotation moves entry i+1 into cell i and the
  // (possibly modified) head into the tail. The write pointer follows rotations.
  entry_t cell_q [TABLE_DEPTH];
  entry_t cell_d [TABLE_DEPTH];
  entry_t head_new;
  logic   shift;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign cell_d[g] = head_new;
    end else begin : g_mid
      assign cell_d[g] = cell_q[g+1];
    end
    rdrt_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .din(cell_d[g]),
                      .dout(cell_q[g]));
  end

  // Record rotation: head holds the slot after write_slot, so a record writes
  // head and rotates; write_slot is implicitly the tail. hslot is the slot
  // currently at the head.
  entry_t h;
  logic   lk_hit, tx_send, tx_dec, room, proc, walk_done;
  logic [47:0] tx_time;
  assign h = cell_q[0];
  assign room = (nres != 5'd16);

  // Entries are handled from the moment slot 0 reaches the head until all
  // TABLE_DEPTH have passed; the walk ends once the write position is home.
  assign proc = (state == ST_WALK) && (cnt != CW'(TABLE_DEPTH)) &&
                ((cnt != '0) || (hslot == '0));
  assign walk_done = (cnt == CW'(TABLE_DEPTH)) && (hslot == home);

  always_comb begin
    lk_hit = 1'b0;
    if (kind == code_rsp) begin
      lk_hit = (h.kind == code_req) && (h.logger != '0) && (h.tag == tag);
    end else begin
      lk_hit = (h.tag == tag) && (h.logger == logger) && (h.kind == kind) &&
               ((kind == code_bc) || (h.etime == etime));
    end
    tx_send = 1'b0;
    tx_dec = 1'b0;
    tx_time = h.etime;
    if (h.retries != 2'd0) begin
      if (h.kind == code_bc || h.kind == code_rsp) begin
        tx_time = etime;
        tx_send = tvld && room;
        tx_dec = !tvld || room;
      end else begin
        if (h.kind == code_req) tx_time = etime;
        tx_send = room;
        tx_dec = room;
      end
    end
    head_new = h;
    case (state)
      ST_REC: begin
        head_new.kind = kind;
        head_new.retries = retx ? RETRY_COUNT : 2'd0;
        if (kind == code_req) begin
          head_new.tag = tag;
          head_new.logger = own_logger_id;
        end else begin
          head_new.tag = tag;
          head_new.logger = logger;
          head_new.etime = etime;
        end
      end
      ST_WALK: begin
        if (proc) begin
          if (op == OP_LOOKUP) begin
            if (lk_hit && !found && kind == code_rsp) head_new.logger = '0;
          end else if (tx_dec) begin
            head_new.retries = h.retries - 2'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // A tick result is held back until the next one or the end of the walk, so
  // the final one can carry tlast; a tick walk stalls while the output is full.
  logic out_busy, tx_load, ans_load;
  assign out_busy = m_axis_tvalid && !m_axis_tready;
  assign shift = (state == ST_REC) ||
                 (state == ST_WALK && !walk_done && !(op == OP_TICK && out_busy));
  assign s_axis_tready = (state == ST_IDLE);
  assign tx_load = shift && proc && (op == OP_TICK) && tx_send && (nres != 5'd0);
  assign ans_load = (state == ST_OUT) && !out_busy &&
                    ((op == OP_LOOKUP) || (nres != 5'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      own_logger_id <= '0; group_id <= '0;
      code_bc <= 8'd127; code_req <= 8'd126; code_rsp <= 8'd125;
    end else if (wr_en) begin
      unique case (wr_index)
        3'd0: own_logger_id <= wr_data;
        3'd1: group_id <= wr_data[15:0];
        3'd2: code_bc <= wr_data[7:0];
        3'd3: code_req <= wr_data[7:0];
        3'd4: code_rsp <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      m_axis_tuser <= 1'b0;
      m_axis_tlast <= 1'b0;
      hslot <= SW'(1);
      cnt <= '0; nres <= '0; scnt <= '0; found <= 1'b0;
    end else begin
      if (tx_load || ans_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (shift) hslot <= (hslot == SW'(TABLE_DEPTH - 1)) ? '0 : hslot + 1'b1;
      unique case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          op <= s_axis_tuser;
          tag <= s_axis_tdata[31:0];
          logger <= s_axis_tdata[63:32];
          etime <= s_axis_tdata[111:64];
          kind <= s_axis_tdata[119:112];
          retx <= s_axis_tdata[120];
          tvld <= s_axis_tdata[121];
          home <= hslot;
          cnt <= '0; nres <= '0; scnt <= '0; found <= 1'b0;
          unique case (s_axis_tuser) inside
            OP_RECORD: state <= (s_axis_tdata[119:112] == code_req) ? ST_SCR : ST_REC;
            OP_LOOKUP, OP_TICK: state <= ST_WALK;
            default: ;
          endcase
        end
        ST_SCR: begin
          tag <= lcg_step(tag);
          scnt <= scnt + 2'd1;
          if (scnt == 2'd3) state <= ST_REC;
        end
        ST_REC: state <= ST_IDLE;
        ST_WALK: begin
          if (walk_done) begin
            state <= ST_OUT;
          end else if (shift && proc) begin
            cnt <= cnt + 1'b1;
            if (op == OP_LOOKUP) begin
              if (lk_hit) found <= 1'b1;
            end else if (tx_send) begin
              if (nres != 5'd0) begin
                m_axis_tuser <= 1'b1;
                m_axis_tlast <= 1'b0;
                m_axis_tdata <= hold_data;
              end
              hold_data <= {7'd0, group_id, h.logger, h.kind, h.tag, tx_time, 1'b0};
              nres <= nres + 5'd1;
            end
          end
        end
        ST_OUT: if (!out_busy) begin
          if (op == OP_LOOKUP) begin
            m_axis_tuser <= 1'b0;
            m_axis_tlast <= 1'b1;
            m_axis_tdata <= {143'd0, found};
          end else if (nres != 5'd0) begin
            m_axis_tuser <= 1'b1;
            m_axis_tlast <= 1'b1;
            m_axis_tdata <= hold_data;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == ST_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("output dropped");
  a_res_cap: assert property (@(posedge clk) disable iff (rst)
    nres <= 5'd16) else $error("result cap exceeded");
endmodule
`default_nettype wire
